// ===== src/udp_port_listener_table_macros.svh =====
// Assertion macros for the UDP port listener table.
// Included by files that carry concurrent checks; expects aclk and aresetn in scope.
`ifndef UDP_PORT_LISTENER_TABLE_MACROS_SVH
`define UDP_PORT_LISTENER_TABLE_MACROS_SVH

// Condition that must hold at every edge out of reset.
`define UPLT_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Same-cycle implication.
`define UPLT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define UPLT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/uplt_pkg.sv =====
// Shared types and constants for the UDP port listener table.
// No dependencies; imported by the controller, datapath and top level.
package uplt_pkg;

    localparam int DEF_MAX_LISTENERS   = 16;
    localparam int DEF_HANDLER_ID_BITS = 8;

    localparam int KIND_W   = 2;
    localparam int PORT_W   = 16;
    localparam int HID_W    = 8;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    localparam logic [KIND_W-1:0] KIND_REGISTER   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UNREGISTER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOOKUP     = 2'd2;

    localparam logic [STATUS_W-1:0] ST_REGISTERED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_IN_USE     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REMOVED    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ABSENT     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_HIT        = 3'd5;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;  // take request, run the parallel port compare
        logic read;     // encode match, read table entry
        logic exec;     // update table, load result register
    } uplt_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic out_valid;  // result register occupied
    } uplt_stat_t;

endpackage

// ===== src/uplt_ctrl.sv =====
// Request sequencer for the UDP port listener table.
// Depends on uplt_pkg; drives the datapath through uplt_cmd_t.
module uplt_ctrl
    import uplt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       m_tready,
    input  uplt_stat_t stat,
    output logic       s_tready,
    output uplt_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       exec_ok;

    assign s_tready = (state_reg == S_IDLE);
    // Result register must be free, or emptied this cycle.
    assign exec_ok  = !stat.out_valid || m_tready;

    assign cmd.capture = s_tvalid && s_tready;
    assign cmd.read    = (state_reg == S_READ);
    assign cmd.exec    = (state_reg == S_EXEC) && exec_ok;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                state_next = S_EXEC;
            end
            S_EXEC: begin
                if (exec_ok) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/uplt_dpath.sv =====
// Table storage, parallel port compare, compaction and result register.
// Depends on uplt_pkg; sequenced by uplt_ctrl.
module uplt_dpath
    import uplt_pkg::*;
#(
    parameter int MAX_LISTENERS   = DEF_MAX_LISTENERS,
    parameter int HANDLER_ID_BITS = DEF_HANDLER_ID_BITS,
    localparam int CNT_W = $clog2(MAX_LISTENERS + 1),
    localparam int IDX_W = (MAX_LISTENERS > 1) ? $clog2(MAX_LISTENERS) : 1,
    localparam int HB_W  = (HANDLER_ID_BITS < HID_W) ? HANDLER_ID_BITS : HID_W
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  uplt_cmd_t           cmd,
    input  logic [KIND_W-1:0]   in_kind,
    input  logic [PORT_W-1:0]   in_port,
    input  logic [HID_W-1:0]    in_handler_id,
    input  logic                m_tready,
    output uplt_stat_t          stat,
    output logic [STATUS_W-1:0] out_status,
    output logic [HID_W-1:0]    out_found_handler,
    output logic [COUNT_W-1:0]  out_entry_count,
    output logic                out_valid,
    output logic [CNT_W-1:0]    live_count
);

    localparam int ENT_W = PORT_W + HB_W;

    // Table: ports in flops for the compare lanes, full entries in a memory.
    logic [PORT_W-1:0]        port_reg [MAX_LISTENERS];
    logic [ENT_W-1:0]         ent_mem  [MAX_LISTENERS];

    logic [KIND_W-1:0]        kind_reg;
    logic [PORT_W-1:0]        req_port_reg;
    logic [HB_W-1:0]          req_hid_reg;
    logic [MAX_LISTENERS-1:0] match_reg;
    logic [IDX_W-1:0]         slot_reg;
    logic                     hit_reg;
    logic [ENT_W-1:0]         rd_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;

    logic [STATUS_W-1:0]      status_reg;
    logic [HID_W-1:0]         found_reg;
    logic [COUNT_W-1:0]       ocount_reg;
    logic                     ovalid_reg;

    logic [MAX_LISTENERS-1:0] match_c;
    logic [IDX_W-1:0]         slot_c;
    logic [CNT_W-1:0]         last_c;
    logic [IDX_W-1:0]         rd_addr;

    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic [ENT_W-1:0]         wr_data;
    logic [STATUS_W-1:0]      status_c;
    logic [HID_W-1:0]         found_c;

    // One compare lane per slot; only slots below the count take part.
    always_comb begin
        for (int i = 0; i < MAX_LISTENERS; i++) begin
            match_c[i] = (port_reg[i] == in_port) && (count_reg > CNT_W'(i));
        end
    end

    // Ports are unique in the table, so the match vector is one-hot or empty.
    always_comb begin
        slot_c = '0;
        for (int i = 0; i < MAX_LISTENERS; i++) begin
            if (match_reg[i]) begin
                slot_c = slot_c | IDX_W'(i);
            end
        end
    end

    assign last_c  = count_reg - CNT_W'(1);
    assign rd_addr = (kind_reg == KIND_UNREGISTER) ? last_c[IDX_W-1:0] : slot_c;

    always_comb begin
        wr_en      = 1'b0;
        wr_addr    = slot_reg;
        wr_data    = rd_reg;
        count_next = count_reg;
        found_c    = '0;
        status_c   = ST_ABSENT;
        case (kind_reg)
            KIND_REGISTER: begin
                if (hit_reg) begin
                    status_c = ST_IN_USE;
                end else if (count_reg >= CNT_W'(MAX_LISTENERS)) begin
                    status_c = ST_FULL;
                end else begin
                    wr_en      = 1'b1;
                    wr_addr    = count_reg[IDX_W-1:0];
                    wr_data    = {req_port_reg, req_hid_reg};
                    count_next = count_reg + CNT_W'(1);
                    status_c   = ST_REGISTERED;
                end
            end
            KIND_UNREGISTER: begin
                if (hit_reg) begin
                    // Last entry moves into the freed slot.
                    wr_en      = 1'b1;
                    count_next = last_c;
                    status_c   = ST_REMOVED;
                end
            end
            default: begin
                if (hit_reg) begin
                    found_c  = HID_W'(rd_reg[HB_W-1:0]);
                    status_c = ST_HIT;
                end
            end
        endcase
    end

    // Request capture and compare.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg     <= in_kind;
            req_port_reg <= in_port;
            req_hid_reg  <= in_handler_id[HB_W-1:0];
            match_reg    <= match_c;
        end
        if (cmd.read) begin
            slot_reg <= slot_c;
            hit_reg  <= |match_reg;
        end
    end

    // Entry memory, registered read.
    always_ff @(posedge aclk) begin
        if (cmd.read) begin
            rd_reg <= ent_mem[rd_addr];
        end
        if (cmd.exec && wr_en) begin
            ent_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_LISTENERS; i++) begin
            if (cmd.exec && wr_en && (wr_addr == IDX_W'(i))) begin
                port_reg[i] <= wr_data[ENT_W-1:HB_W];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            status_reg <= status_c;
            found_reg  <= found_c;
            ocount_reg <= COUNT_W'(count_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            if (cmd.exec) begin
                count_reg  <= count_next;
                ovalid_reg <= 1'b1;
            end else if (m_tready) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    assign stat.out_valid    = ovalid_reg;
    assign out_valid         = ovalid_reg;
    assign out_status        = status_reg;
    assign out_found_handler = found_reg;
    assign out_entry_count   = ocount_reg;
    assign live_count        = count_reg;

endmodule

// ===== src/udp_port_listener_table.sv =====
// UDP port listener table, top level.
// Requests arrive on the s_ stream: tuser carries the kind (register, unregister,
// lookup; the unused code is treated as a lookup), tdata the port and handler id.
// Each request gives exactly one result on the m_ stream: tuser carries the status,
// tdata the handler found on a lookup hit and the entry count after the request.
// Entries are kept packed in slots 0..count-1; unregister moves the last entry
// into the freed slot. Register of a port already present reports in use and
// leaves the stored handler alone.
// Steps: on acceptance the request is captured and the compare runs (all slots in
// parallel); then comes the registered entry-memory read, and then the table
// update, which loads the result register and raises m_tvalid.
// One request is in flight at a time and s_tready returns only after the update,
// so a new request is not taken until the previous one has been through it.
// The result sits in an output register; the next request is accepted while it
// waits. If the receiver stalls, the following request stops before its update
// step until the result register is taken, and s_tready stays low meanwhile.
// Reset (aresetn low, synchronous) empties the table and drops any pending result;
// table contents are not cleared, only the count.
`include "udp_port_listener_table_macros.svh"

module udp_port_listener_table
    import uplt_pkg::*;
#(
    parameter int MAX_LISTENERS   = DEF_MAX_LISTENERS,
    parameter int HANDLER_ID_BITS = DEF_HANDLER_ID_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] port, [23:16] handler_id
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] found_handler, [12:8] entry_count, rest zero
    output logic [2:0]  m_tuser    // [2:0] status
);

    localparam int CNT_W = $clog2(MAX_LISTENERS + 1);

    uplt_cmd_t           cmd;
    uplt_stat_t          stat;
    logic [STATUS_W-1:0] out_status;
    logic [HID_W-1:0]    out_found;
    logic [COUNT_W-1:0]  out_count;
    logic                out_valid;
    logic [CNT_W-1:0]    live_count;

    uplt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    uplt_dpath #(
        .MAX_LISTENERS   (MAX_LISTENERS),
        .HANDLER_ID_BITS (HANDLER_ID_BITS)
    ) u_dpath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .in_kind           (s_tuser[KIND_W-1:0]),
        .in_port           (s_tdata[PORT_W-1:0]),
        .in_handler_id     (s_tdata[PORT_W+HID_W-1:PORT_W]),
        .m_tready          (m_tready),
        .stat              (stat),
        .out_status        (out_status),
        .out_found_handler (out_found),
        .out_entry_count   (out_count),
        .out_valid         (out_valid),
        .live_count        (live_count)
    );

    assign m_tvalid = out_valid;
    assign m_tuser  = out_status;
    assign m_tdata  = {3'b000, out_count, out_found};

    // Checks
    `UPLT_ASSERT_ALWAYS(a_count_bound, live_count <= CNT_W'(MAX_LISTENERS), "entry count above table size")
    `UPLT_ASSERT_IMPL(a_full_count, m_tvalid && (m_tuser == ST_FULL), live_count == CNT_W'(MAX_LISTENERS), "table full reported below capacity")
    `UPLT_ASSERT_IMPL(a_miss_zero, m_tvalid && (m_tuser != ST_HIT), m_tdata[HID_W-1:0] == '0, "handler id on a result that is not a hit")
    `UPLT_ASSERT_NEXT(a_one_inflight, s_tvalid && s_tready, !s_tready, "second request taken while one is in flight")

endmodule
